// ===== rtl/core/tcs_pkg.sv =====
package tcs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TAG_BITS    = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_SHOW    = 3'd1,
        EV_HIDE    = 3'd2,
        EV_STORED  = 3'd3,
        EV_DROPPED = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PEND_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_SHOW_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] cue_start;
        logic signed [31:0] cue_stop;
        logic [15:0]        cue_tag;
        logic signed [31:0] now_ms;
    } cue_in_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [7:0]         shown_index;
        logic [15:0]        shown_tag;
        logic signed [31:0] shown_stop;
    } cue_out_t;

endpackage

// ===== rtl/core/timed_cue_show_hide_scheduler.sv =====
// Append, flush, unknown commands and a tick on an empty table pass from the execute
// step straight to the output step; a tick also runs through its forward scans, which
// visit table entries one at a time, a read step and then a compare step per entry.
// One transaction at a time; the scan over the cue memory, one entry read and one
// shared compare per entry, sets the tick time.
// Reset clears all control state and sets show_enable; the cue memory keeps its data.
module timed_cue_show_hide_scheduler (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tcs_pkg::cue_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tcs_pkg::cue_out_t m_data,
    input  logic              show_enable_we,
    input  logic              show_enable_wdata
);
    import tcs_pkg::*;

    logic signed [31:0] start_mem [TABLE_DEPTH];
    logic signed [31:0] stop_mem  [TABLE_DEPTH];
    logic [TAG_BITS-1:0] tag_mem  [TABLE_DEPTH];

    logic signed [31:0]  start_rd_reg;
    logic signed [31:0]  stop_rd_reg;
    logic [TAG_BITS-1:0] tag_rd_reg;

    state_t             state_reg, state_next;
    cue_in_t            in_reg;
    logic [CNT_W-1:0]   cue_count_reg, cue_count_next;
    logic [CNT_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               pend_valid_reg, pend_valid_next;
    logic signed [31:0] shown_end_reg, shown_end_next;
    logic               showing_reg, showing_next;
    logic signed [31:0] prev_now_reg, prev_now_next;
    logic signed [31:0] last_stop_reg, last_stop_next;
    logic               post_show_reg, post_show_next;
    logic               show_enable_reg;
    cue_out_t           res_reg, res_next;
    logic               m_valid_reg;
    cue_out_t           m_data_reg;

    logic               wr_en;
    logic signed [31:0] wr_stop;
    logic signed [31:0] cmp_a, cmp_b;
    logic               cmp_lt;
    logic               pend_in_range;
    logic               out_load;

    assign cmp_lt        = cmp_a < cmp_b;
    assign pend_in_range = pend_idx_reg < cue_count_reg;
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_mem[cue_count_reg[IDX_W-1:0]] <= in_reg.cue_start;
            stop_mem[cue_count_reg[IDX_W-1:0]]  <= wr_stop;
            tag_mem[cue_count_reg[IDX_W-1:0]]   <= in_reg.cue_tag[TAG_BITS-1:0];
        end
        start_rd_reg <= start_mem[pend_idx_reg[IDX_W-1:0]];
        stop_rd_reg  <= stop_mem[pend_idx_reg[IDX_W-1:0]];
        tag_rd_reg   <= tag_mem[pend_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cue_count_reg   <= '0;
            pend_idx_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            shown_end_reg   <= INT_MIN;
            showing_reg     <= 1'b0;
            prev_now_reg    <= '0;
            post_show_reg   <= 1'b0;
            show_enable_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cue_count_reg  <= cue_count_next;
            pend_idx_reg   <= pend_idx_next;
            pend_valid_reg <= pend_valid_next;
            shown_end_reg  <= shown_end_next;
            showing_reg    <= showing_next;
            prev_now_reg   <= prev_now_next;
            post_show_reg  <= post_show_next;
            if (show_enable_we) begin
                show_enable_reg <= show_enable_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (out_load) begin
            m_data_reg <= res_reg;
        end
        last_stop_reg <= last_stop_next;
        res_reg       <= res_next;
    end

    always_comb begin
        cmp_a = in_reg.now_ms;
        cmp_b = prev_now_reg;
        unique case (state_reg)
            ST_EXEC: begin
                if (in_reg.command == CMD_APPEND) begin
                    cmp_a = in_reg.cue_stop;
                    cmp_b = last_stop_reg;
                end
            end
            ST_PEND_CMP, ST_SCAN_CMP: begin
                cmp_b = stop_rd_reg;
            end
            ST_DECIDE: begin
                cmp_b = shown_end_reg;
            end
            ST_SHOW_CMP: begin
                cmp_b = start_rd_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        cue_count_next  = cue_count_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        shown_end_next  = shown_end_reg;
        showing_next    = showing_reg;
        prev_now_next   = prev_now_reg;
        last_stop_next  = last_stop_reg;
        post_show_next  = post_show_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_stop         = in_reg.cue_stop;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next       = '0;
                res_next.event_kind = EV_NONE;
                post_show_next = 1'b0;
                state_next     = ST_OUT;
                unique case (cmd_t'(in_reg.command))
                    CMD_APPEND: begin
                        if (show_enable_reg && (cue_count_reg < CNT_W'(TABLE_DEPTH))) begin
                            if ((cue_count_reg != '0) && cmp_lt) begin
                                wr_stop = last_stop_reg;
                            end
                            wr_en               = 1'b1;
                            last_stop_next      = wr_stop;
                            cue_count_next      = cue_count_reg + CNT_W'(1);
                            res_next.event_kind = EV_STORED;
                        end else begin
                            res_next.event_kind = EV_DROPPED;
                        end
                    end
                    CMD_TICK: begin
                        if (cue_count_reg != '0) begin
                            prev_now_next = in_reg.now_ms;
                            if (cmp_lt) begin
                                shown_end_next  = INT_MIN;
                                pend_idx_next   = '0;
                                pend_valid_next = 1'b0;
                                state_next      = ST_SCAN_RD;
                            end else if (pend_valid_reg && pend_in_range) begin
                                state_next = ST_PEND_CMP;
                            end else if (!pend_valid_reg) begin
                                state_next = ST_SCAN_RD;
                            end else begin
                                state_next = ST_DECIDE;
                            end
                        end
                    end
                    CMD_FLUSH: begin
                        cue_count_next      = '0;
                        pend_idx_next       = '0;
                        pend_valid_next     = 1'b0;
                        shown_end_next      = INT_MIN;
                        showing_next        = 1'b0;
                        prev_now_next       = '0;
                        res_next.event_kind = EV_HIDE;
                    end
                    default: begin
                        res_next.event_kind = EV_NONE;
                    end
                endcase
            end
            ST_PEND_CMP: begin
                if (!cmp_lt) begin
                    shown_end_next  = INT_MIN;
                    pend_idx_next   = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SCAN_RD;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_SCAN_RD: begin
                if (pend_in_range) begin
                    state_next = ST_SCAN_CMP;
                end else begin
                    state_next = post_show_reg ? ST_OUT : ST_DECIDE;
                end
            end
            ST_SCAN_CMP: begin
                if (cmp_lt) begin
                    pend_valid_next = 1'b1;
                    state_next      = post_show_reg ? ST_OUT : ST_DECIDE;
                end else begin
                    pend_idx_next = pend_idx_reg + CNT_W'(1);
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_DECIDE: begin
                state_next = ST_OUT;
                if (!cmp_lt) begin
                    if (pend_valid_reg && pend_in_range) begin
                        state_next = ST_SHOW_CMP;
                    end else if (showing_reg) begin
                        showing_next        = 1'b0;
                        res_next.event_kind = EV_HIDE;
                    end
                end
            end
            ST_SHOW_CMP: begin
                state_next = ST_OUT;
                if (!cmp_lt) begin
                    res_next.event_kind  = EV_SHOW;
                    res_next.shown_index = 8'(pend_idx_reg);
                    res_next.shown_tag   = 16'(tag_rd_reg);
                    res_next.shown_stop  = stop_rd_reg;
                    showing_next         = 1'b1;
                    shown_end_next       = stop_rd_reg;
                    pend_idx_next        = pend_idx_reg + CNT_W'(1);
                    pend_valid_next      = 1'b0;
                    post_show_next       = 1'b1;
                    state_next           = ST_SCAN_RD;
                end else if (showing_reg) begin
                    showing_next        = 1'b0;
                    res_next.event_kind = EV_HIDE;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A valid pending cue always points inside the filled part of the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (pend_idx_reg < cue_count_reg))
        else $error("pending cue lies beyond the table fill");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cue_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("table fill exceeds the table depth");

    // A new result appears only when the sequencer hands it over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not dispatched");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_kind != EV_SHOW) |->
            (m_data.shown_index == '0 && m_data.shown_tag == '0 && m_data.shown_stop == '0))
        else $error("cue fields set on a result that is not a show");

endmodule
